>>> hdl/kfe_pkg.sv
// Shared types, constants and mode codes of the kernel function evaluator.
package kfe_pkg;

  localparam int unsigned ELEM_WIDTH      = 16;
  localparam int unsigned EXP_TABLE_DEPTH = 256;
  localparam int unsigned DVD_W           = 44;

  localparam logic [31:0] LOG2E_LO = 32'h7154_7653;
  localparam logic [31:0] LN2_Q20  = 32'd726817;
  localparam logic [63:0] SQ_LIMIT = 64'd3037000499;
  localparam logic signed [63:0] MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] ONE_Q24 = 64'sh0000_0000_0100_0000;

  typedef enum logic [1:0] {
    KM_DOT     = 2'd0,
    KM_QUAD    = 2'd1,
    KM_RADIAL  = 2'd2,
    KM_WRADIAL = 2'd3
  } kmode_e;

  typedef struct packed {
    logic signed [ELEM_WIDTH-1:0] a_elem;
    logic signed [ELEM_WIDTH-1:0] b_elem;
    logic [ELEM_WIDTH-1:0]        weight_elem;
    logic                         last_elem;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] kernel_value;
    logic               saturated;
    logic               zero_weight;
  } out_word_t;

endpackage

>>> hdl/kfe_mul.sv
// Shared unsigned 32 by 32 multiplier with a registered product.
module kfe_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);
  logic [63:0] p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= '0;
    end else begin
      p_q <= {32'b0, a_i} * {32'b0, b_i};
    end
  end

  assign p_o = p_q;
endmodule

>>> hdl/kfe_div.sv
// Restoring divider, one quotient bit per cycle.
module kfe_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [kfe_pkg::DVD_W-1:0] dividend_i,
  input  logic [31:0]               divisor_i,
  output logic                      done_o,
  output logic [kfe_pkg::DVD_W-1:0] quotient_o
);
  import kfe_pkg::*;

  localparam int unsigned CW = $clog2(DVD_W + 1);

  logic [31:0]      rem_q;
  logic [DVD_W-1:0] quo_q;
  logic [31:0]      dvs_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [32:0]      rem_sh, rem_diff;
  logic             ge;

  assign rem_sh   = {rem_q, quo_q[DVD_W-1]};
  assign ge       = rem_sh >= {1'b0, dvs_q};
  assign rem_diff = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      rem_q  <= '0;
      quo_q  <= dividend_i;
      dvs_q  <= divisor_i;
      cnt_q  <= CW'(DVD_W);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      rem_q  <= ge ? rem_diff[31:0] : rem_sh[31:0];
      quo_q  <= {quo_q[DVD_W-2:0], ge};
      cnt_q  <= cnt_q - CW'(1);
      busy_q <= cnt_q != CW'(1);
      done_q <= cnt_q == CW'(1);
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

>>> hdl/kfe_exp_rom.sv
// Table of 2^(-k/DEPTH) in Q2.30 with a registered read port.
module kfe_exp_rom #(
  parameter int unsigned DEPTH = kfe_pkg::EXP_TABLE_DEPTH
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  output logic [31:0]              data_o
);
  import kfe_pkg::*;

  typedef logic [31:0] tab_t [DEPTH];

  // Taylor series of exp(-k ln2 / DEPTH), evaluated at elaboration.
  function automatic tab_t build_tab();
    tab_t        t;
    logic [63:0] ln2, u, term, sum;
    logic [127:0] pr;
    for (int k = 0; k < DEPTH; k++) begin
      ln2  = 64'hB172_17F7_D1CF_79AB >> 4;
      u    = (ln2 / DEPTH) * 64'(k) + ((ln2 % DEPTH) * 64'(k)) / DEPTH;
      term = 64'h1000_0000_0000_0000;
      sum  = 64'h1000_0000_0000_0000;
      for (int i = 1; i <= 24; i++) begin
        pr = {64'b0, term} * {64'b0, u};
        term = pr[123:60];
        case (i)
          2:  term = term / 64'd2;
          3:  term = term / 64'd3;
          4:  term = term / 64'd4;
          5:  term = term / 64'd5;
          6:  term = term / 64'd6;
          7:  term = term / 64'd7;
          8:  term = term / 64'd8;
          9:  term = term / 64'd9;
          10: term = term / 64'd10;
          11: term = term / 64'd11;
          12: term = term / 64'd12;
          13: term = term / 64'd13;
          14: term = term / 64'd14;
          15: term = term / 64'd15;
          16: term = term / 64'd16;
          17: term = term / 64'd17;
          18: term = term / 64'd18;
          19: term = term / 64'd19;
          20: term = term / 64'd20;
          21: term = term / 64'd21;
          22: term = term / 64'd22;
          23: term = term / 64'd23;
          24: term = term / 64'd24;
          default: term = term;
        endcase
        if (i % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      pr   = {64'b0, sum + 64'h2000_0000} >> 30;
      t[k] = pr[31:0];
    end
    return t;
  endfunction

  localparam tab_t TAB = build_tab();

  logic [31:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= TAB[addr_i];
  end

  assign data_o = data_q;
endmodule

>>> hdl/kernel_function_evaluator.sv
// Top level of the kernel function evaluator: sequencer around shared units.
// A non-closing word holds the block for its multiply and accumulate steps; in weighted
// radial mode it first waits on the divider, unless its weight is zero. A closing word
// then runs the closing steps of its mode (the radial modes stop early when the sum is
// so large that the result is zero), and waits further while an earlier result is unread.
// One word is worked at a time. Reset clears the accumulator, the flags and the mode (dot).
module kernel_function_evaluator #(
  parameter int unsigned EXP_TABLE_DEPTH = kfe_pkg::EXP_TABLE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  kfe_pkg::in_word_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output kfe_pkg::out_word_t out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_data_i
);
  import kfe_pkg::*;

  localparam int unsigned KW = $clog2(EXP_TABLE_DEPTH);
  localparam logic [31:0] DEPTH32 = 32'(EXP_TABLE_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE, S_DIV, S_TMUL, S_TACC, S_ENDCHK,
    S_Q1, S_Q2, S_Q3, S_Q4, S_Q5,
    S_E1, S_E2, S_E3, S_E4, S_E5, S_E6, S_E7, S_E8, S_E9, S_E10,
    S_E12, S_E13, S_E14, S_E15,
    S_OUT
  } state_e;

  // Saturating add: returns the overflow flag above the clamped sum.
  function automatic logic [64:0] sat_add(logic signed [63:0] a, logic signed [63:0] t);
    logic signed [64:0] s;
    s = {a[63], a} + {t[63], t};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, MIN64} : {1'b1, MAX64};
    end
    return {1'b0, s[63:0]};
  endfunction

  state_e             state_q;
  kmode_e             mode_q, imode_q;
  logic               last_q, neg_q, term_max_q;
  logic [31:0]        op_a_q, op_b_q;
  logic signed [63:0] acc_q;
  logic               sat_q, werr_q;
  logic [127:0]       wide_q;
  logic [63:0]        x_q;
  logic [4:0]         n_q;
  logic [43:0]        f44_q, r_q;
  logic [KW-1:0]      k_q;
  logic [29:0]        v30_q;
  logic [31:0]        e30_q;
  logic [63:0]        res_q;
  logic               out_valid_q;
  out_word_t          out_q;

  // Shared units.
  logic [31:0]      mul_a, mul_b, tab;
  logic [63:0]      p;
  logic             div_start, div_done;
  logic [DVD_W-1:0] div_dvd, div_q;
  logic [31:0]      div_dvs;

  kfe_mul u_mul (.clk_i, .rst_ni, .a_i(mul_a), .b_i(mul_b), .p_o(p));

  kfe_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_dvd),
    .divisor_i(div_dvs), .done_o(div_done), .quotient_o(div_q)
  );

  kfe_exp_rom #(.DEPTH(EXP_TABLE_DEPTH)) u_rom (.clk_i, .addr_i(k_q), .data_o(tab));

  // Element arithmetic on the incoming word, wide enough for any element.
  logic signed [33:0] a_x, b_x, d_x, am_x, bm_x, dm_x;
  logic               accept;

  assign a_x  = 34'(in_data_i.a_elem);
  assign b_x  = 34'(in_data_i.b_elem);
  assign d_x  = a_x - b_x;
  assign am_x = a_x[33] ? -a_x : a_x;
  assign bm_x = b_x[33] ? -b_x : b_x;
  assign dm_x = d_x[33] ? -d_x : d_x;

  assign in_ready_o  = state_q == S_IDLE;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Multiplier operands follow the sequencer step; the product is registered and comes in the next cycle.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_TMUL: begin mul_a = op_a_q;       mul_b = op_b_q;   end
      S_Q1:   begin mul_a = x_q[63:32];   mul_b = x_q[63:32]; end
      S_Q2:   begin mul_a = x_q[63:32];   mul_b = x_q[31:0]; end
      S_Q3:   begin mul_a = x_q[31:0];    mul_b = x_q[31:0]; end
      S_E1:   begin mul_a = x_q[31:0];    mul_b = LOG2E_LO; end
      S_E2:   begin mul_a = x_q[63:32];   mul_b = LOG2E_LO; end
      S_E5:   begin mul_a = f44_q[31:0];  mul_b = DEPTH32;  end
      S_E6:   begin mul_a = 32'(f44_q[43:32]); mul_b = DEPTH32; end
      S_E8:   begin mul_a = r_q[31:0];    mul_b = LN2_Q20;  end
      S_E9:   begin mul_a = 32'(r_q[43:32]); mul_b = LN2_Q20; end
      S_E12:  begin mul_a = 32'(v30_q);   mul_b = 32'(v30_q); end
      S_E14:  begin mul_a = tab;          mul_b = e30_q;    end
      default: begin mul_a = '0;          mul_b = '0;       end
    endcase
  end

  // Partial products are summed 32 bits up where the sequencer splits an operand.
  logic [127:0] wide_p32;
  assign wide_p32 = wide_q + {32'b0, p, 32'b0};

  // The divider serves the weighted quotient only; it starts as the word is taken.
  assign div_start = accept && mode_q == KM_WRADIAL && in_data_i.weight_elem != '0;
  assign div_dvd   = {dm_x[31:0], 12'b0};
  assign div_dvs   = 32'(in_data_i.weight_elem);

  // Per-step values computed ahead of the clocked block.
  logic signed [63:0] term;
  logic [64:0]        acc_sum, quad_s;
  logic [63:0]        mag;
  logic [27:0]        kraw;
  logic [5:0]         shamt;

  assign term    = term_max_q ? MAX64 : (neg_q ? -$signed(p) : $signed(p));
  assign acc_sum = sat_add(acc_q, term);
  assign quad_s  = sat_add(acc_q, ONE_Q24);
  assign mag     = quad_s[63] ? 64'(-$signed(quad_s[63:0])) : quad_s[63:0];
  assign kraw    = wide_p32[71:44];
  assign shamt   = 6'd36 + 6'(n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= KM_DOT;
      imode_q     <= KM_DOT;
      last_q      <= 1'b0;
      neg_q       <= 1'b0;
      term_max_q  <= 1'b0;
      op_a_q      <= '0;
      op_b_q      <= '0;
      acc_q       <= '0;
      sat_q       <= 1'b0;
      werr_q      <= 1'b0;
      wide_q      <= '0;
      x_q         <= '0;
      n_q         <= '0;
      f44_q       <= '0;
      r_q         <= '0;
      k_q         <= '0;
      v30_q       <= '0;
      e30_q       <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        mode_q <= kmode_e'(cfg_data_i);
      end
      // A word taken while a new result is loaded is handled by the output step.
      if (out_valid_q && out_ready_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            imode_q    <= mode_q;
            last_q     <= in_data_i.last_elem;
            neg_q      <= 1'b0;
            term_max_q <= 1'b0;
            unique case (mode_q)
              KM_DOT, KM_QUAD: begin
                op_a_q  <= am_x[31:0];
                op_b_q  <= bm_x[31:0];
                neg_q   <= a_x[33] ^ b_x[33];
                state_q <= S_TMUL;
              end
              KM_RADIAL: begin
                op_a_q <= dm_x[31:0];
                op_b_q <= dm_x[31:0];
                if (64'(dm_x) > SQ_LIMIT) begin
                  term_max_q <= 1'b1;
                  sat_q      <= 1'b1;
                  state_q    <= S_TACC;
                end else begin
                  state_q <= S_TMUL;
                end
              end
              KM_WRADIAL: begin
                if (in_data_i.weight_elem == '0) begin
                  // A zero weight contributes nothing and raises the error flag.
                  werr_q  <= 1'b1;
                  state_q <= S_ENDCHK;
                end else begin
                  state_q <= S_DIV;
                end
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            op_a_q <= div_q[31:0];
            op_b_q <= div_q[31:0];
            if (64'(div_q) > SQ_LIMIT) begin
              term_max_q <= 1'b1;
              sat_q      <= 1'b1;
              state_q    <= S_TACC;
            end else begin
              state_q <= S_TMUL;
            end
          end
        end
        S_TMUL: state_q <= S_TACC;
        S_TACC: begin
          acc_q   <= acc_sum[63:0];
          sat_q   <= sat_q | acc_sum[64];
          state_q <= S_ENDCHK;
        end
        S_ENDCHK: begin
          if (!last_q) begin
            state_q <= S_IDLE;
          end else begin
            unique case (imode_q)
              KM_DOT: begin
                res_q   <= acc_q;
                state_q <= S_OUT;
              end
              KM_QUAD: begin
                sat_q   <= sat_q | quad_s[64];
                x_q     <= mag;
                state_q <= S_Q1;
              end
              default: begin
                // A negative sum in a radial mode counts as zero.
                x_q     <= acc_q[63] ? 64'b0 : acc_q;
                state_q <= S_E1;
              end
            endcase
          end
        end
        // Quadratic: square of the 64-bit magnitude from three partial products.
        S_Q1: state_q <= S_Q2;
        S_Q2: begin
          wide_q  <= {p, 64'b0};
          state_q <= S_Q3;
        end
        S_Q3: begin
          wide_q  <= wide_q + {31'b0, p, 33'b0};
          state_q <= S_Q4;
        end
        S_Q4: begin
          wide_q  <= wide_q + {64'b0, p};
          state_q <= S_Q5;
        end
        S_Q5: begin
          if (wide_q[127:87] != '0) begin
            sat_q <= 1'b1;
            res_q <= MAX64;
          end else begin
            res_q <= wide_q[87:24];
          end
          state_q <= S_OUT;
        end
        // Radial: x times log2(e) splits into integer and fractional powers of two.
        S_E1: state_q <= S_E2;
        S_E2: begin
          wide_q  <= {32'b0, x_q, 32'b0} + {64'b0, p};
          state_q <= S_E3;
        end
        S_E3: begin
          wide_q  <= wide_p32;
          state_q <= S_E4;
        end
        S_E4: begin
          if (wide_q[127:56] >= 72'd28) begin
            res_q   <= '0;
            state_q <= S_OUT;
          end else begin
            n_q     <= wide_q[60:56];
            f44_q   <= wide_q[55:12];
            state_q <= S_E5;
          end
        end
        S_E5: state_q <= S_E6;
        S_E6: begin
          wide_q  <= {64'b0, p};
          state_q <= S_E7;
        end
        S_E7: begin
          if (kraw >= 28'(EXP_TABLE_DEPTH)) begin
            k_q <= KW'(EXP_TABLE_DEPTH - 1);
          end else begin
            k_q <= kraw[KW-1:0];
          end
          r_q     <= wide_p32[43:0];
          state_q <= S_E8;
        end
        S_E8: state_q <= S_E9;
        S_E9: begin
          wide_q  <= {64'b0, p};
          state_q <= S_E10;
        end
        S_E10: begin
          // The residue times ln2 is scaled down by the table depth, a power of two,
          // and kept in Q.30.
          v30_q   <= 30'(wide_p32[63:0] >> (34 + KW));
          state_q <= S_E12;
        end
        S_E12: state_q <= S_E13;
        S_E13: begin
          // Second-order correction for the residue below one table step.
          e30_q   <= 32'h4000_0000 - 32'(v30_q) + 32'(p[63:31]);
          state_q <= S_E14;
        end
        S_E14: state_q <= S_E15;
        S_E15: begin
          res_q   <= p >> shamt;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.kernel_value <= res_q;
            out_q.saturated    <= sat_q;
            out_q.zero_weight  <= werr_q;
            out_valid_q        <= 1'b1;
            acc_q              <= '0;
            sat_q              <= 1'b0;
            werr_q             <= 1'b0;
            state_q            <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

>>> test/kernel_function_evaluator_tb.sv
// Self-checking testbench of the kernel function evaluator, with a predicting scoreboard.
`timescale 1ns / 100ps

// Scoreboard: predicts the kernel value of every closed vector and checks the output words.
class kernel_scoreboard;
  kfe_pkg::out_word_t kernel_q[$];
  kfe_pkg::kmode_e    mode;
  longint             acc;
  bit                 sat;
  bit                 werr;
  logic [31:0]        exp_tab[256];
  int                 errors;

  function new();
    mode   = kfe_pkg::KM_DOT;
    acc    = 0;
    sat    = 0;
    werr   = 0;
    errors = 0;
    build_exp_table();
  endfunction

  // Table of 2^(-k/256) in Q2.30, from a series of exp(-k*ln2/256) up to the 24th power.
  function void build_exp_table();
    logic [63:0]  ln2, u, term, sum, kk;
    logic [127:0] p;
    ln2 = 64'hB172_17F7_D1CF_79AB >> 4;
    for (int k = 0; k < 256; k++) begin
      kk   = k;
      u    = (ln2 / 256) * kk + ((ln2 % 256) * kk) / 256;
      term = 64'd1 << 60;
      sum  = 64'd1 << 60;
      for (int i = 1; i <= 24; i++) begin
        p    = {64'd0, term} * {64'd0, u};
        term = p[123:60] / i;
        if (i % 2) sum = sum - term;
        else sum = sum + term;
      end
      exp_tab[k] = 32'((sum + (64'd1 << 29)) >> 30);
    end
  endfunction

  function longint sat_add(longint a, longint t);
    if (t > 0 && a > kfe_pkg::MAX64 - t) begin
      sat = 1;
      return kfe_pkg::MAX64;
    end
    if (t < 0 && a < kfe_pkg::MIN64 - t) begin
      sat = 1;
      return kfe_pkg::MIN64;
    end
    return a + t;
  endfunction

  function longint square_of(logic [63:0] m);
    if (m > kfe_pkg::SQ_LIMIT) begin
      sat = 1;
      return kfe_pkg::MAX64;
    end
    return longint'(m * m);
  endfunction

  // exp(-x) in Q.24: split x*log2(e) into whole and fractional parts, the
  // fraction indexes the table and the remainder gets a second-order fix-up.
  function longint exp_neg(logic [63:0] x);
    logic [127:0] p;
    logic [63:0]  n, f44, prod, k, r, v44, v30, e30;
    p = {64'd0, x} * {64'd0, 64'h1_7154_7653};
    if (p[127:120] != 0) return 0;
    n = p[119:56];
    if (n >= 28) return 0;
    f44  = {20'd0, p[55:12]};
    prod = f44 * 256;
    k    = prod >> 44;
    r    = prod & ((64'd1 << 44) - 1);
    v44  = ((r * 64'd726817) >> 20) / 256;
    v30  = v44 >> 14;
    e30  = (64'd1 << 30) - v30 + ((v30 * v30) >> 31);
    return longint'(({32'd0, exp_tab[k]} * e30) >> (36 + n));
  endfunction

  // Notes an accepted input word; a closing word queues one expected result.
  function void note_word(kfe_pkg::in_word_t w);
    longint             a, b, d, s;
    logic [63:0]        dm, wt, mag;
    logic [127:0]       p;
    kfe_pkg::out_word_t r;
    a  = longint'(w.a_elem);
    b  = longint'(w.b_elem);
    wt = {48'd0, w.weight_elem};
    d  = a - b;
    dm = (d < 0) ? -d : d;
    case (mode)
      kfe_pkg::KM_DOT, kfe_pkg::KM_QUAD: acc = sat_add(acc, a * b);
      kfe_pkg::KM_RADIAL: acc = sat_add(acc, square_of(dm));
      default: begin
        if (wt == 0) werr = 1;
        else acc = sat_add(acc, square_of((dm << 12) / wt));
      end
    endcase
    if (!w.last_elem) return;
    case (mode)
      kfe_pkg::KM_DOT: r.kernel_value = acc;
      kfe_pkg::KM_QUAD: begin
        s   = sat_add(acc, kfe_pkg::ONE_Q24);
        mag = (s < 0) ? 64'd0 - s : s;
        p   = {64'd0, mag} * {64'd0, mag};
        if (p[127:87] != 0) begin
          sat            = 1;
          r.kernel_value = kfe_pkg::MAX64;
        end else begin
          r.kernel_value = p[87:24];
        end
      end
      default: r.kernel_value = exp_neg((acc < 0) ? 64'd0 : acc);
    endcase
    r.saturated   = sat;
    r.zero_weight = werr;
    kernel_q.push_back(r);
    acc  = 0;
    sat  = 0;
    werr = 0;
  endfunction

  function void check_word(kfe_pkg::out_word_t got);
    kfe_pkg::out_word_t want;
    if (kernel_q.size() == 0) begin
      $error("kernel_value %0d arrived with no result expected", got.kernel_value);
      errors++;
      return;
    end
    want = kernel_q.pop_front();
    if (got.kernel_value !== want.kernel_value) begin
      $error("kernel_value: expected %0d, got %0d", want.kernel_value, got.kernel_value);
      errors++;
    end
    if (got.saturated !== want.saturated) begin
      $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
      errors++;
    end
    if (got.zero_weight !== want.zero_weight) begin
      $error("zero_weight: expected %0b, got %0b", want.zero_weight, got.zero_weight);
      errors++;
    end
  endfunction
endclass

module kernel_function_evaluator_tb;
  import kfe_pkg::*;

  // Generous bound: even weighted vectors with full stalls finish well inside it.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_WORDS = 1950;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0] cfg_data;

  kernel_scoreboard kernels = new();
  int  in_idle_pct  = 22;
  int  out_idle_pct = 22;
  bit  hold_request = 0;
  int  cycles       = 0;

  kernel_function_evaluator uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Watchdog: a hung handshake must not keep the run going for ever.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL kernel_function_evaluator");
      $finish;
    end
  end

  // Result side. The ready line is decided once per cycle; a hold-off request
  // turns into a long stretch of low ready, counted here, so that the block
  // fills up and stops taking input words.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 0;
        hold_left    = 600;
      end
      if (hold_left > 0) out_ready <= 1'b0;
      else out_ready <= ($urandom_range(99) >= out_idle_pct);
      @(posedge clk);
      if (out_valid && out_ready && rst_n) kernels.check_word(out_data);
      if (hold_left > 0) hold_left--;
    end
  end

  // Offers one word and waits for its acceptance. The valid line is left high,
  // so the next call either keeps it up with new data or drops it for a gap.
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    kernels.note_word(w);
  endtask

  // Drops valid and waits until every expected result has come back, then
  // lets the longest word latency pass, as a non-closing word gives no result.
  task automatic drain();
    in_valid <= 1'b0;
    while (kernels.kernel_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_mode(kmode_e m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    kernels.mode = m;
  endtask

  task automatic send_pair(int a, int b, int wt, bit last);
    in_word_t w;
    w.a_elem      = 16'(a);
    w.b_elem      = 16'(b);
    w.weight_elem = 16'(wt);
    w.last_elem   = last;
    send_word(w);
  endtask

  // Element values: extremes, small values that keep radial results alive,
  // and fully random words so that every bit toggles.
  function automatic logic [15:0] pick_elem();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2, 3, 4: return 16'($signed($urandom_range(4095)) - 2048);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(11))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(15, 1));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int sent;
    int len;
    in_word_t w;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = KM_DOT;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Dot product straight after reset, extremes of both vectors.
    send_pair(32767, 32767, 0, 0);
    send_pair(-32768, -32768, 0, 1);
    send_pair(-32768, 32767, 0, 1);

    // Quadratic: a negative sum, the empty sum giving exactly one, and a sum of one giving four.
    set_mode(KM_QUAD);
    send_pair(-32768, 32767, 65535, 1);
    send_pair(0, 0, 0, 1);
    send_pair(4096, 4096, 0, 1);

    // Radial: a zero distance gives one, the largest distance underflows to zero.
    set_mode(KM_RADIAL);
    send_pair(0, 0, 0, 1);
    send_pair(32767, -32768, 0, 1);
    send_pair(4096, 0, 0, 1);

    // Weighted radial: zero weight flagged, largest weight, smallest weight.
    set_mode(KM_WRADIAL);
    send_pair(4096, 0, 0, 1);
    send_pair(4096, 0, 4096, 0);
    send_pair(0, 0, 65535, 1);
    send_pair(32767, -32768, 1, 1);

    // Mode changed mid-vector: a negative dot sum then closed as radial, which
    // must read the negative sum as zero; then radial terms closed as weighted.
    set_mode(KM_DOT);
    send_pair(-32768, 32767, 0, 0);
    set_mode(KM_RADIAL);
    send_pair(0, 0, 0, 1);
    send_pair(100, -100, 0, 0);
    set_mode(KM_WRADIAL);
    send_pair(64, 0, 0, 1);

    // Random part: phases of about 245 words, each under its own mode. Phase 2
    // runs with no idling on either side; phase 5 opens with a long hold-off.
    sent = 0;
    for (int phase = 0; phase < 8; phase++) begin
      set_mode(phase < 4 ? kmode_e'(phase) : kmode_e'($urandom_range(3)));
      in_idle_pct  = (phase == 2) ? 0 : 22;
      out_idle_pct = in_idle_pct;
      if (phase == 5) hold_request = 1;
      while (sent < (phase + 1) * RANDOM_WORDS / 8) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 1);
        for (int i = 0; i < len; i++) begin
          w.a_elem      = pick_elem();
          w.b_elem      = ($urandom_range(3) == 0) ? w.a_elem : pick_elem();
          w.weight_elem = pick_weight();
          w.last_elem   = (i == len - 1);
          send_word(w);
          sent++;
        end
      end
    end

    in_idle_pct  = 22;
    out_idle_pct = 22;
    drain();
    if (kernels.errors == 0) begin
      $display("PASS kernel_function_evaluator");
    end else begin
      $display("FAIL kernel_function_evaluator");
    end
    $finish;
  end
endmodule
